// ===== hdl/scfe_pkg.sv =====
// Shared types, constants and codes for the servo CAN command frame encoder.
package scfe_pkg;

	// Fixed-point format of all physical values
	localparam int FRAC_BITS = 16;

	// Operation codes
	localparam logic [2:0] OP_MOTION    = 3'd0;
	localparam logic [2:0] OP_ENABLE    = 3'd1;
	localparam logic [2:0] OP_DISABLE   = 3'd2;
	localparam logic [2:0] OP_RESET     = 3'd3;
	localparam logic [2:0] OP_SET_ZERO  = 3'd4;
	localparam logic [2:0] OP_REG_WRITE = 3'd5;

	// Configuration register indexes
	localparam logic [2:0] CFG_LAYOUT    = 3'd0;
	localparam logic [2:0] CFG_POS_LIMIT = 3'd1;
	localparam logic [2:0] CFG_VEL_LIMIT = 3'd2;
	localparam logic [2:0] CFG_TOR_LIMIT = 3'd3;
	localparam logic [2:0] CFG_KP_LIMIT  = 3'd4;
	localparam logic [2:0] CFG_KD_LIMIT  = 3'd5;

	// Frame constants
	localparam logic [10:0] REG_WRITE_ID  = 11'h7FF;
	localparam logic [7:0]  REG_WRITE_TAG = 8'h55;
	localparam logic [7:0]  FILL_BYTE     = 8'hFF;
	localparam logic [7:0]  CMD_ENABLE    = 8'hFC;
	localparam logic [7:0]  CMD_DISABLE   = 8'hFD;
	localparam logic [7:0]  CMD_RESET     = 8'hFB;
	localparam logic [7:0]  CMD_SET_ZERO  = 8'hFE;

	// Reset values of the limits, truncated to register width
	localparam logic [21:0] POS_LIMIT_RST = 22'(64'd25 << (FRAC_BITS - 1));
	localparam logic [21:0] VEL_LIMIT_RST = 22'(64'd10 << FRAC_BITS);
	localparam logic [21:0] TOR_LIMIT_RST = 22'(64'd28 << FRAC_BITS);
	localparam logic [24:0] KP_LIMIT_RST  = 25'(64'd500 << FRAC_BITS);
	localparam logic [18:0] KD_LIMIT_RST  = 19'(64'd5 << FRAC_BITS);

	// Quantiser lanes
	localparam int LANES    = 5;
	localparam int LANE_POS = 0;
	localparam int LANE_VEL = 1;
	localparam int LANE_TOR = 2;
	localparam int LANE_KP  = 3;
	localparam int LANE_KD  = 4;

	// Datapath widths: offset value, divisor, numerator, quotient
	localparam int C_W       = 26;
	localparam int N_W       = 42;
	localparam int Q_W       = 16;
	localparam int DIV_STEPS = Q_W;

	// Register stages from request to result strobe
	localparam int LATENCY = DIV_STEPS + 3;

	typedef struct packed {
		logic [2:0]  op;
		logic [10:0] id;
		logic [7:0]  addr;
		logic [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic        layout;
		logic [21:0] pos_limit;
		logic [21:0] vel_limit;
		logic [21:0] tor_limit;
		logic [24:0] kp_limit;
		logic [18:0] kd_limit;
	} cfg_t;

	typedef logic [LANES-1:0][C_W-1:0] lane_c_t;
	typedef logic [LANES-1:0][N_W-1:0] lane_n_t;
	typedef logic [LANES-1:0][Q_W-1:0] lane_q_t;

endpackage

// ===== hdl/scfe_cfg.sv =====
// Configuration register bank of the frame encoder.
module scfe_cfg import scfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.layout    <= 1'b0;
			cfg_q.pos_limit <= POS_LIMIT_RST;
			cfg_q.vel_limit <= VEL_LIMIT_RST;
			cfg_q.tor_limit <= TOR_LIMIT_RST;
			cfg_q.kp_limit  <= KP_LIMIT_RST;
			cfg_q.kd_limit  <= KD_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LAYOUT:    cfg_q.layout    <= cfg_data[0];
				CFG_POS_LIMIT: cfg_q.pos_limit <= cfg_data[21:0];
				CFG_VEL_LIMIT: cfg_q.vel_limit <= cfg_data[21:0];
				CFG_TOR_LIMIT: cfg_q.tor_limit <= cfg_data[21:0];
				CFG_KP_LIMIT:  cfg_q.kp_limit  <= cfg_data[24:0];
				CFG_KD_LIMIT:  cfg_q.kd_limit  <= cfg_data[18:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== hdl/scfe_prep.sv =====
// Clamp, offset and numerator stages feeding the quantiser divider.
module scfe_prep import scfe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_in,
	input  cmd_t               cmd_in,
	input  logic signed [25:0] stiffness,
	input  logic signed [19:0] damping,
	input  logic signed [22:0] position,
	input  logic signed [22:0] velocity,
	input  logic signed [22:0] torque,
	input  cfg_t               cfg,
	output logic               valid_s2,
	output cmd_t               cmd_s2,
	output lane_n_t            n_s2,
	output lane_c_t            d_s2
);

	logic    valid_s1;
	cmd_t    cmd_s1;
	lane_c_t c_s1;
	lane_c_t d_s1;
	lane_c_t c_comb;
	lane_c_t d_comb;

	// Symmetric range: clamp to [-lim, lim] and shift up by lim
	function automatic logic [C_W-1:0] sym_offset(input logic signed [22:0] x,
			input logic [21:0] lim);
		logic signed [23:0] xe;
		logic signed [23:0] le;
		logic signed [23:0] s;
		xe = {x[22], x};
		le = {2'b00, lim};
		if (xe > le)
			s = le + le;
		else if (xe < -le)
			s = '0;
		else
			s = xe + le;
		return {2'b00, s};
	endfunction

	// Gain range: clamp to [0, lim]
	function automatic logic [C_W-1:0] gain_clamp(input logic [C_W-1:0] x,
			input logic [C_W-1:0] lim);
		if (x[C_W-1])
			return '0;
		else if (x > lim)
			return lim;
		else
			return x;
	endfunction

	// Numerator c * (2^bits - 1)
	function automatic logic [N_W-1:0] scale(input logic [C_W-1:0] c, input logic [4:0] bits);
		logic [N_W-1:0] ce;
		ce = {{(N_W-C_W){1'b0}}, c};
		return (ce << bits) - ce;
	endfunction

	// Stage 1 datapath
	always_comb begin
		c_comb[LANE_POS] = sym_offset(position, cfg.pos_limit);
		c_comb[LANE_VEL] = sym_offset(velocity, cfg.vel_limit);
		c_comb[LANE_TOR] = sym_offset(torque, cfg.tor_limit);
		c_comb[LANE_KP]  = gain_clamp(stiffness, {1'b0, cfg.kp_limit});
		c_comb[LANE_KD]  = gain_clamp({{(C_W-20){damping[19]}}, damping},
			{{(C_W-19){1'b0}}, cfg.kd_limit});
		d_comb[LANE_POS] = {3'b000, cfg.pos_limit, 1'b0};
		d_comb[LANE_VEL] = {3'b000, cfg.vel_limit, 1'b0};
		d_comb[LANE_TOR] = {3'b000, cfg.tor_limit, 1'b0};
		d_comb[LANE_KP]  = {1'b0, cfg.kp_limit};
		d_comb[LANE_KD]  = {{(C_W-19){1'b0}}, cfg.kd_limit};
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		cmd_s1 <= cmd_in;
		c_s1   <= c_comb;
		d_s1   <= d_comb;
		cmd_s2 <= cmd_s1;
		d_s2   <= d_s1;
		n_s2[LANE_POS] <= scale(c_s1[LANE_POS], 5'd16);
		n_s2[LANE_VEL] <= scale(c_s1[LANE_VEL], 5'd12);
		n_s2[LANE_TOR] <= scale(c_s1[LANE_TOR], 5'd12);
		n_s2[LANE_KP]  <= scale(c_s1[LANE_KP], 5'd12);
		n_s2[LANE_KD]  <= scale(c_s1[LANE_KD], cfg.layout ? 5'd9 : 5'd12);
	end

endmodule

// ===== hdl/scfe_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage on every lane.
module scfe_divider import scfe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    valid_in,
	input  cmd_t    cmd_in,
	input  lane_n_t n_in,
	input  lane_c_t d_in,
	output logic    valid_out,
	output cmd_t    cmd_out,
	output lane_q_t q_out
);

	logic    v_s   [DIV_STEPS];
	cmd_t    cmd_s [DIV_STEPS];
	lane_n_t n_s   [DIV_STEPS];
	lane_c_t d_s   [DIV_STEPS];
	lane_q_t q_s   [DIV_STEPS];

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
		localparam int SH = DIV_STEPS - 1 - g;
		logic    v_prev;
		cmd_t    cmd_prev;
		lane_n_t n_prev;
		lane_c_t d_prev;
		lane_q_t q_prev;
		lane_n_t n_next;
		lane_q_t q_next;

		if (g == 0) begin : g_first
			always_comb begin
				v_prev   = valid_in;
				cmd_prev = cmd_in;
				n_prev   = n_in;
				d_prev   = d_in;
				q_prev   = '0;
			end
		end else begin : g_rest
			always_comb begin
				v_prev   = v_s[g-1];
				cmd_prev = cmd_s[g-1];
				n_prev   = n_s[g-1];
				d_prev   = d_s[g-1];
				q_prev   = q_s[g-1];
			end
		end

		// Trial subtract of the shifted divisor; zero span gives zero
		always_comb begin
			logic [N_W-1:0] trial;
			for (int l = 0; l < LANES; l++) begin
				trial = {{(N_W-C_W){1'b0}}, d_prev[l]} << SH;
				n_next[l] = n_prev[l];
				q_next[l] = q_prev[l];
				if (d_prev[l] != '0 && n_prev[l] >= trial) begin
					n_next[l]     = n_prev[l] - trial;
					q_next[l][SH] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[g] <= 1'b0;
			else
				v_s[g] <= v_prev;
		end

		always_ff @(posedge clk) begin
			cmd_s[g] <= cmd_prev;
			n_s[g]   <= n_next;
			d_s[g]   <= d_prev;
			q_s[g]   <= q_next;
		end
	end

	assign valid_out = v_s[DIV_STEPS-1];
	assign cmd_out   = cmd_s[DIV_STEPS-1];
	assign q_out     = q_s[DIV_STEPS-1];

endmodule

// ===== hdl/scfe_pack.sv =====
// Frame assembly and output register.
module scfe_pack import scfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_in,
	input  cmd_t        cmd_in,
	input  lane_q_t     q_in,
	input  logic        layout,
	output logic        result_valid,
	output logic [10:0] frame_id,
	output logic [63:0] frame_data
);

	logic [7:0]  b [8];
	logic [10:0] fid;
	logic [15:0] pos;
	logic [11:0] vel;
	logic [11:0] tor;
	logic [11:0] kp;
	logic [11:0] kd;
	logic [63:0] data_comb;

	assign pos = q_in[LANE_POS];
	assign vel = q_in[LANE_VEL][11:0];
	assign tor = q_in[LANE_TOR][11:0];
	assign kp  = q_in[LANE_KP][11:0];
	assign kd  = q_in[LANE_KD][11:0];

	// Byte layout per operation
	always_comb begin
		fid = cmd_in.id;
		for (int k = 0; k < 8; k++)
			b[k] = FILL_BYTE;
		case (cmd_in.op)
			OP_MOTION: begin
				if (!layout) begin
					b[0] = pos[15:8];
					b[1] = pos[7:0];
					b[2] = vel[11:4];
					b[3] = {vel[3:0], kp[11:8]};
					b[4] = kp[7:0];
					b[5] = kd[11:4];
					b[6] = {kd[3:0], tor[11:8]};
					b[7] = tor[7:0];
				end else begin
					b[0] = {3'b000, kp[11:7]};
					b[1] = {kp[6:0], kd[8]};
					b[2] = kd[7:0];
					b[3] = pos[15:8];
					b[4] = pos[7:0];
					b[5] = vel[11:4];
					b[6] = {vel[3:0], tor[11:8]};
					b[7] = tor[7:0];
				end
			end
			OP_ENABLE:   b[7] = CMD_ENABLE;
			OP_DISABLE:  b[7] = CMD_DISABLE;
			OP_RESET:    b[7] = CMD_RESET;
			OP_SET_ZERO: b[7] = CMD_SET_ZERO;
			OP_REG_WRITE: begin
				fid  = REG_WRITE_ID;
				b[0] = cmd_in.id[7:0];
				b[1] = {5'b00000, cmd_in.id[10:8]};
				b[2] = REG_WRITE_TAG;
				b[3] = cmd_in.addr;
				b[4] = cmd_in.value[7:0];
				b[5] = cmd_in.value[15:8];
				b[6] = cmd_in.value[23:16];
				b[7] = cmd_in.value[31:24];
			end
			default: ;
		endcase
		for (int k = 0; k < 8; k++)
			data_comb[8*k +: 8] = b[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid <= 1'b0;
		else
			result_valid <= valid_in;
	end

	always_ff @(posedge clk) begin
		frame_id   <= fid;
		frame_data <= data_comb;
	end

endmodule

// ===== hdl/servo_can_command_frame_encoder_core.sv =====
// A request taken gives its frame through the pipeline below (strobe result_valid).
// Throughput: one request per cycle; busy stays low, set by the 19-stage pipeline
// (clamp, numerator, 16 one-bit divider steps, frame register).
// Operation codes 6 and 7 are taken and give no frame.
// Reset (arst_n low) clears the valid bits and loads the default limits and layout 0.
// The result strobe cannot be held off by the receiver.
module servo_can_command_frame_encoder_core import scfe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         operation,
	input  logic [10:0]        node_id,
	input  logic signed [25:0] stiffness,
	input  logic signed [19:0] damping,
	input  logic signed [22:0] position,
	input  logic signed [22:0] velocity,
	input  logic signed [22:0] torque,
	input  logic [7:0]         reg_address,
	input  logic [31:0]        reg_value,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               result_valid,
	output logic [10:0]        frame_id,
	output logic [63:0]        frame_data
);

	cfg_t    cfg;
	cmd_t    cmd_in;
	logic    valid_in;
	logic    valid_s2;
	cmd_t    cmd_s2;
	lane_n_t n_s2;
	lane_c_t d_s2;
	logic    div_valid;
	cmd_t    div_cmd;
	lane_q_t div_q;

	// Always ready: pipeline never stalls
	assign busy     = 1'b0;
	assign valid_in = start && !busy && (operation <= OP_REG_WRITE);

	assign cmd_in.op    = operation;
	assign cmd_in.id    = node_id;
	assign cmd_in.addr  = reg_address;
	assign cmd_in.value = reg_value;

	scfe_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	scfe_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (valid_in),
		.cmd_in    (cmd_in),
		.stiffness (stiffness),
		.damping   (damping),
		.position  (position),
		.velocity  (velocity),
		.torque    (torque),
		.cfg       (cfg),
		.valid_s2  (valid_s2),
		.cmd_s2    (cmd_s2),
		.n_s2      (n_s2),
		.d_s2      (d_s2)
	);

	scfe_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (valid_s2),
		.cmd_in    (cmd_s2),
		.n_in      (n_s2),
		.d_in      (d_s2),
		.valid_out (div_valid),
		.cmd_out   (div_cmd),
		.q_out     (div_q)
	);

	scfe_pack u_pack (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_in     (div_valid),
		.cmd_in       (div_cmd),
		.q_in         (div_q),
		.layout       (cfg.layout),
		.result_valid (result_valid),
		.frame_id     (frame_id),
		.frame_data   (frame_data)
	);

	// Every frame traces back to a known request a fixed latency earlier
	a_frame_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy && operation <= OP_REG_WRITE, LATENCY))
		else $error("frame without matching request");

	// Register write requests come out on the broadcast identifier
	a_reg_write_id: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && $past(start && operation == OP_REG_WRITE, LATENCY)
			|-> frame_id == REG_WRITE_ID)
		else $error("register write frame has wrong identifier");

	// Enable and reset commands keep the node identifier
	a_fixed_cmd_id: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && $past(start && (operation == OP_ENABLE || operation == OP_RESET), LATENCY)
			|-> frame_id == $past(node_id, LATENCY))
		else $error("fixed command frame has wrong identifier");

endmodule
